### rtl/core/tkdhr_pkg.sv
// Shared types and constants for the touch key debounce/hold/repeat core.
// No dependencies.
package tkdhr_pkg;

  typedef enum logic [2:0] {
    REG_BASELINE     = 3'd0,
    REG_HYSTERESIS   = 3'd1,
    REG_DEBOUNCE_MS  = 3'd2,
    REG_HELD_MS      = 3'd3,
    REG_REPEAT_MS    = 3'd4,
    REG_LONG_HELD_MS = 3'd5
  } reg_idx_t;

  localparam logic [15:0] RST_DEBOUNCE_MS  = 16'd20;
  localparam logic [15:0] RST_HELD_MS      = 16'd500;
  localparam logic [15:0] RST_REPEAT_MS    = 16'd100;
  localparam logic [15:0] RST_LONG_HELD_MS = 16'd2000;

  typedef struct packed {
    logic [15:0] baseline;
    logic [15:0] hysteresis;
    logic [15:0] debounce_ms;
    logic [15:0] held_ms;
    logic [15:0] repeat_ms;
    logic [15:0] long_held_ms;
  } cfg_t;

  typedef struct packed {
    logic [15:0] now_ms;
    logic [15:0] now_mark;
    logic        press;
  } item_t;

  typedef struct packed {
    logic pressed;
    logic changed;
    logic activated;
    logic deactivated;
    logic held;
    logic repeat_pulse;
    logic hold_long;
  } res_t;

endpackage

### rtl/core/tkdhr_cfg.sv
// Configuration register file with APB-style access.
// Depends on tkdhr_pkg.
module tkdhr_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output tkdhr_pkg::cfg_t    cfg
);

  tkdhr_pkg::cfg_t     cfg_r;
  tkdhr_pkg::cfg_t     cfg_nxt;
  tkdhr_pkg::reg_idx_t idx;
  logic                wr_en;

  assign pready = 1'b1;
  assign idx    = tkdhr_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        tkdhr_pkg::REG_BASELINE:     cfg_nxt.baseline     = pwdata[15:0];
        tkdhr_pkg::REG_HYSTERESIS:   cfg_nxt.hysteresis   = pwdata[15:0];
        tkdhr_pkg::REG_DEBOUNCE_MS:  cfg_nxt.debounce_ms  = pwdata[15:0];
        tkdhr_pkg::REG_HELD_MS:      cfg_nxt.held_ms      = pwdata[15:0];
        tkdhr_pkg::REG_REPEAT_MS:    cfg_nxt.repeat_ms    = pwdata[15:0];
        tkdhr_pkg::REG_LONG_HELD_MS: cfg_nxt.long_held_ms = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      tkdhr_pkg::REG_BASELINE:     prdata = {16'd0, cfg_r.baseline};
      tkdhr_pkg::REG_HYSTERESIS:   prdata = {16'd0, cfg_r.hysteresis};
      tkdhr_pkg::REG_DEBOUNCE_MS:  prdata = {16'd0, cfg_r.debounce_ms};
      tkdhr_pkg::REG_HELD_MS:      prdata = {16'd0, cfg_r.held_ms};
      tkdhr_pkg::REG_REPEAT_MS:    prdata = {16'd0, cfg_r.repeat_ms};
      tkdhr_pkg::REG_LONG_HELD_MS: prdata = {16'd0, cfg_r.long_held_ms};
      default:                     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.baseline     <= 16'd0;
      cfg_r.hysteresis   <= 16'd0;
      cfg_r.debounce_ms  <= tkdhr_pkg::RST_DEBOUNCE_MS;
      cfg_r.held_ms      <= tkdhr_pkg::RST_HELD_MS;
      cfg_r.repeat_ms    <= tkdhr_pkg::RST_REPEAT_MS;
      cfg_r.long_held_ms <= tkdhr_pkg::RST_LONG_HELD_MS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### rtl/core/tkdhr_front.sv
// Input register: captures a tick, its loop-unit mark and the raw press compare.
// Depends on tkdhr_pkg.
module tkdhr_front #(
  parameter int LOOP_MS = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        now_ms,
  input  logic [15:0]        touch_value,
  input  tkdhr_pkg::cfg_t    cfg,
  output logic               item_valid,
  output tkdhr_pkg::item_t   item,
  input  logic               item_take
);

  localparam int          SH    = 16 + $clog2(LOOP_MS);
  localparam logic [16:0] RECIP = 17'(((1 << SH) + LOOP_MS - 1) / LOOP_MS);

  logic             valid_r;
  tkdhr_pkg::item_t item_r;
  logic [16:0]      touch_sum;
  logic [39:0]      mark_prod;

  assign in_ready   = !valid_r || item_take;
  assign item_valid = valid_r;
  assign item       = item_r;
  assign touch_sum  = {1'b0, touch_value} + {1'b0, cfg.hysteresis};
  // Divide by the loop period through a rounded-up reciprocal, exact for 16-bit times.
  assign mark_prod  = {24'd0, now_ms} * {23'd0, RECIP};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.now_ms   <= now_ms;
      item_r.now_mark <= mark_prod[SH +: 16];
      item_r.press    <= touch_sum < {1'b0, cfg.baseline};
    end
  end

endmodule

### rtl/core/tkdhr_eval.sv
// Key state update and result register: debounce, hold, repeat and long hold.
// Depends on tkdhr_pkg.
module tkdhr_eval #(
  parameter int LOOP_MS = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tkdhr_pkg::cfg_t    cfg,
  input  logic               item_valid,
  input  tkdhr_pkg::item_t   item,
  output logic               item_take,
  output logic               out_valid,
  input  logic               out_ready,
  output tkdhr_pkg::res_t    res
);

  localparam int LW = $clog2(LOOP_MS + 1);
  localparam int PW = 16 + LW;

  logic            level_r, level_nxt;
  logic            held_r, held_nxt;
  logic            lh_r, lh_nxt;
  logic [15:0]     cmark_r, cmark_nxt;
  logic [15:0]     rmark_r, rmark_nxt;
  logic [15:0]     ticks_r, ticks_nxt;
  logic            out_valid_r;
  tkdhr_pkg::res_t res_r, res_nxt;

  logic [PW-1:0]   cmark_scaled;
  logic [PW-1:0]   rmark_scaled;
  logic [PW-1:0]   press_time;
  logic [15:0]     since_change;
  logic [15:0]     since_repeat;
  logic            chg;
  logic            rep;

  assign item_take = item_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign res       = res_r;

  assign cmark_scaled = PW'(cmark_r) * PW'(LOOP_MS);
  assign rmark_scaled = PW'(rmark_r) * PW'(LOOP_MS);
  assign press_time   = PW'(ticks_r) * PW'(LOOP_MS);
  assign since_change = item.now_ms - cmark_scaled[15:0];
  assign since_repeat = item.now_ms - rmark_scaled[15:0];

  always_comb begin
    lh_nxt    = (ticks_r == 16'd0) ? 1'b0 : lh_r;
    chg       = (since_change >= cfg.debounce_ms) && (level_r != item.press);
    level_nxt = chg ? !level_r : level_r;
    cmark_nxt = chg ? item.now_mark : cmark_r;
    held_nxt  = held_r;
    rmark_nxt = rmark_r;
    ticks_nxt = ticks_r;
    rep       = 1'b0;

    if (held_r) begin
      rep = since_repeat >= cfg.repeat_ms;
      if (rep) begin
        rmark_nxt = item.now_mark;
      end
    end else if (level_nxt && (press_time >= PW'(cfg.held_ms))) begin
      held_nxt  = 1'b1;
      rmark_nxt = 16'd0;
    end

    if (level_nxt && (press_time >= PW'(cfg.long_held_ms))) begin
      lh_nxt = 1'b1;
    end else if (!chg && level_nxt && (ticks_r != 16'hFFFF)) begin
      ticks_nxt = ticks_r + 16'd1;
    end

    if (chg) begin
      ticks_nxt = 16'd0;
      held_nxt  = 1'b0;
    end

    res_nxt.pressed      = level_nxt;
    res_nxt.changed      = chg;
    res_nxt.activated    = chg && item.press;
    res_nxt.deactivated  = chg && !item.press;
    res_nxt.held         = held_nxt;
    res_nxt.repeat_pulse = rep;
    res_nxt.hold_long    = lh_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= 1'b0;
      held_r      <= 1'b0;
      lh_r        <= 1'b0;
      cmark_r     <= 16'd0;
      rmark_r     <= 16'd0;
      ticks_r     <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (item_take) begin
        level_r <= level_nxt;
        held_r  <= held_nxt;
        lh_r    <= lh_nxt;
        cmark_r <= cmark_nxt;
        rmark_r <= rmark_nxt;
        ticks_r <= ticks_nxt;
      end
      if (item_take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      res_r <= res_nxt;
    end
  end

  a_edge_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.activated && res_r.deactivated))
    else $error("activated and deactivated together");

  a_change_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.changed |-> (res_r.activated != res_r.deactivated))
    else $error("change without edge kind");

  a_state_match: assert property (@(posedge clk) disable iff (!rst_n)
    item_take |=> (res_r.pressed == level_r) && (res_r.held == held_r)
                  && (res_r.hold_long == lh_r))
    else $error("result disagrees with stored state");

  a_change_clears: assert property (@(posedge clk) disable iff (!rst_n)
    item_take && chg |=> (ticks_r == 16'd0) && !held_r)
    else $error("hold state not cleared on toggle");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !item_take |=> $stable(ticks_r) && $stable(level_r) && $stable(cmark_r))
    else $error("state moved without a transfer");

endmodule

### rtl/core/touch_key_debounce_hold_repeat_core.sv
// Touch key debouncer with hold, auto-repeat and long-hold detection. One tick
// transfer is accepted every clock cycle while the output is not stalled; its
// result passes through the input register, then the state update into the result
// register, before it is valid on the output. Throughput is one item per cycle
// while the output is not stalled. Registers sit at byte addresses 0, 4, .. 20 and
// must be written only while idle; the block itself does not enforce this.
// Depends on tkdhr_pkg, tkdhr_cfg, tkdhr_front and tkdhr_eval.
module touch_key_debounce_hold_repeat_core #(
  parameter int LOOP_MS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,     // now_ms[15:0], touch_value[31:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,    // pressed, changed, activated, deactivated,
                                    // held, repeat_pulse, long_held, pad zero
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  tkdhr_pkg::cfg_t  cfg;
  tkdhr_pkg::item_t item;
  tkdhr_pkg::res_t  res;
  logic             item_valid;
  logic             item_take;

  tkdhr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  tkdhr_front #(.LOOP_MS(LOOP_MS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .now_ms      (in_tdata[15:0]),
    .touch_value (in_tdata[31:16]),
    .cfg         (cfg),
    .item_valid  (item_valid),
    .item        (item),
    .item_take   (item_take)
  );

  tkdhr_eval #(.LOOP_MS(LOOP_MS)) u_eval (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .res        (res)
  );

  assign out_tdata = {1'b0, res.hold_long, res.repeat_pulse, res.held,
                      res.deactivated, res.activated, res.changed, res.pressed};

endmodule

### tb/sv/tkdhr_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the touch key debounce/hold/repeat core: tracks register writes,
// predicts one key state per accepted tick and compares it with each result transfer.
// Depends on tkdhr_pkg.
module tkdhr_checker #(
  parameter int LOOP_MS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          mismatches,
  output int          states_due
);

  tkdhr_pkg::cfg_t knob;
  logic            level_q;
  logic            held_q;
  logic            long_q;
  logic [15:0]     change_mark;
  logic [15:0]     repeat_mark;
  logic [15:0]     press_ticks;
  tkdhr_pkg::res_t key_states_due[$];
  int              ticks_seen;

  function automatic logic [15:0] since_ms(input logic [15:0] now, input logic [15:0] mark);
    return now - 16'(32'(mark) * LOOP_MS);
  endfunction

  function automatic tkdhr_pkg::res_t debounce_tick(input logic [15:0] now,
                                                    input logic [15:0] touch);
    logic            press;
    logic            toggled;
    logic            rep;
    logic [31:0]     press_time;
    tkdhr_pkg::res_t r;
    press      = ({1'b0, touch} + {1'b0, knob.hysteresis}) < {1'b0, knob.baseline};
    press_time = 32'(press_ticks) * LOOP_MS;
    toggled    = 1'b0;
    rep        = 1'b0;
    if (press_ticks == 16'd0) long_q = 1'b0;
    if (since_ms(now, change_mark) >= knob.debounce_ms && level_q != press) begin
      change_mark = 16'(now / LOOP_MS);
      level_q     = !level_q;
      toggled     = 1'b1;
    end
    if (held_q) begin
      if (since_ms(now, repeat_mark) >= knob.repeat_ms) begin
        repeat_mark = 16'(now / LOOP_MS);
        rep         = 1'b1;
      end
    end else if (level_q && press_time >= knob.held_ms) begin
      held_q      = 1'b1;
      repeat_mark = 16'd0;
    end
    if (level_q && press_time >= knob.long_held_ms) begin
      long_q = 1'b1;
    end else if (!toggled && level_q && press_ticks != 16'hffff) begin
      press_ticks = press_ticks + 16'd1;
    end
    if (toggled) begin
      press_ticks = 16'd0;
      held_q      = 1'b0;
    end
    r.pressed      = level_q;
    r.changed      = toggled;
    r.activated    = toggled && press;
    r.deactivated  = toggled && !press;
    r.held         = held_q;
    r.repeat_pulse = rep;
    r.hold_long    = long_q;
    return r;
  endfunction

  always @(posedge clk) begin
    tkdhr_pkg::res_t got;
    tkdhr_pkg::res_t want;
    if (!rst_n) begin
      knob = '{16'd0, 16'd0, tkdhr_pkg::RST_DEBOUNCE_MS, tkdhr_pkg::RST_HELD_MS,
               tkdhr_pkg::RST_REPEAT_MS, tkdhr_pkg::RST_LONG_HELD_MS};
      level_q     = 1'b0;
      held_q      = 1'b0;
      long_q      = 1'b0;
      change_mark = 16'd0;
      repeat_mark = 16'd0;
      press_ticks = 16'd0;
      ticks_seen  = 0;
      key_states_due.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (tkdhr_pkg::reg_idx_t'(cfg_paddr[4:2]))
          tkdhr_pkg::REG_BASELINE:     knob.baseline     = cfg_pwdata[15:0];
          tkdhr_pkg::REG_HYSTERESIS:   knob.hysteresis   = cfg_pwdata[15:0];
          tkdhr_pkg::REG_DEBOUNCE_MS:  knob.debounce_ms  = cfg_pwdata[15:0];
          tkdhr_pkg::REG_HELD_MS:      knob.held_ms      = cfg_pwdata[15:0];
          tkdhr_pkg::REG_REPEAT_MS:    knob.repeat_ms    = cfg_pwdata[15:0];
          tkdhr_pkg::REG_LONG_HELD_MS: knob.long_held_ms = cfg_pwdata[15:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        key_states_due.push_back(debounce_tick(in_tdata[15:0], in_tdata[31:16]));
      if (out_tvalid && out_tready) begin
        got = '{out_tdata[0], out_tdata[1], out_tdata[2], out_tdata[3],
                out_tdata[4], out_tdata[5], out_tdata[6]};
        if (key_states_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result transfer, tdata %b", $realtime, out_tdata);
        end else begin
          want = key_states_due.pop_front();
          if (got !== want || out_tdata[7] !== 1'b0) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: tick %0d (pressed changed act deact held rep long)",
                        " exp %b got %b pad %b"},
                       $realtime, ticks_seen, want, got, out_tdata[7]);
          end
        end
        ticks_seen++;
      end
    end
    states_due = key_states_due.size();
  end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top of the touch key core testbench: clock, reset, tick and register stimulus
// with random idling on both channels, and the final verdict.
// Depends on tkdhr_pkg, touch_key_debounce_hold_repeat_core and tkdhr_checker.
module tb_top;

  localparam int LOOP_MS = 10;

  logic            clk = 1'b0;
  logic            rst_n;
  logic            in_tvalid;
  logic            in_tready;
  logic [31:0]     in_tdata;
  logic            out_tvalid;
  logic            out_tready;
  logic [7:0]      out_tdata;
  logic            cfg_psel;
  logic            cfg_penable;
  logic            cfg_pwrite;
  logic [4:0]      cfg_paddr;
  logic [31:0]     cfg_pwdata;
  logic [31:0]     cfg_prdata;
  logic            cfg_pready;
  int              mismatches;
  int              states_due;

  tkdhr_pkg::cfg_t setting;
  logic [15:0]     clock_ms;
  bit              quiet_tx;
  tkdhr_pkg::cfg_t plan[5];
  int              plan_ticks[5];
  int              plan_run[5];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  touch_key_debounce_hold_repeat_core #(.LOOP_MS(LOOP_MS)) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  tkdhr_checker #(.LOOP_MS(LOOP_MS)) i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .mismatches  (mismatches),
    .states_due  (states_due)
  );

  function automatic int draw_gap(input bit quiet);
    return quiet ? 0 : $urandom_range(0, 9);
  endfunction

  // Touch reading on the requested side of the press threshold.
  function automatic logic [15:0] pick_touch(input bit want_press);
    int cut;
    cut = int'(setting.baseline) - int'(setting.hysteresis);
    if (cut <= 0) return 16'($urandom);
    if (want_press)
      return ($urandom_range(0, 3) == 0) ? 16'(cut - 1) : 16'($urandom_range(0, cut - 1));
    return ($urandom_range(0, 3) == 0) ? 16'(cut) : 16'($urandom_range(cut, 65535));
  endfunction

  task automatic send_tick(input logic [15:0] now, input logic [15:0] touch);
    int gap;
    if ($urandom_range(0, 39) == 0) quiet_tx = !quiet_tx;
    gap = draw_gap(quiet_tx);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {touch, now};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic write_reg(input tkdhr_pkg::reg_idx_t idx, input logic [15:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {16'($urandom), val};
    @(negedge clk) cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
  endtask

  task automatic apply_setting(input tkdhr_pkg::cfg_t s);
    write_reg(tkdhr_pkg::REG_BASELINE, s.baseline);
    write_reg(tkdhr_pkg::REG_HYSTERESIS, s.hysteresis);
    write_reg(tkdhr_pkg::REG_DEBOUNCE_MS, s.debounce_ms);
    write_reg(tkdhr_pkg::REG_HELD_MS, s.held_ms);
    write_reg(tkdhr_pkg::REG_REPEAT_MS, s.repeat_ms);
    write_reg(tkdhr_pkg::REG_LONG_HELD_MS, s.long_held_ms);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    setting = s;
  endtask

  // Drain: hold the tick channel idle until every expected state has arrived.
  task automatic settle();
    in_tvalid <= 1'b0;
    wait (states_due == 0);
    repeat (4) @(negedge clk);
  endtask

  // Runs of steady touch level with occasional bounce, time skew and jumps.
  task automatic run_ticks(input int count, input int max_run);
    int  run;
    bit  want;
    while (count > 0) begin
      want = $urandom_range(0, 1);
      run  = $urandom_range(1, max_run);
      for (int k = 0; k < run && count > 0; k++) begin
        case ($urandom_range(0, 19))
          0:       clock_ms = 16'($urandom);
          1, 2:    clock_ms = clock_ms + 16'($urandom_range(0, 30));
          default: clock_ms = clock_ms + 16'(LOOP_MS);
        endcase
        send_tick(clock_ms, pick_touch(($urandom_range(0, 15) == 0) ? !want : want));
        count--;
      end
    end
  endtask

  initial begin
    bit quiet_rx;
    int gap;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk) out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        if ($urandom_range(0, 39) == 0) quiet_rx = !quiet_rx;
        gap = draw_gap(quiet_rx);
        if (gap != 0) begin
          @(negedge clk) out_tready <= 1'b0;
          repeat (gap - 1) @(negedge clk);
          @(negedge clk) out_tready <= 1'b1;
        end
      end
    end
  end

  initial begin
    logic [15:0] touch;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    setting     = '{16'd0, 16'd0, tkdhr_pkg::RST_DEBOUNCE_MS, tkdhr_pkg::RST_HELD_MS,
                    tkdhr_pkg::RST_REPEAT_MS, tkdhr_pkg::RST_LONG_HELD_MS};
    plan[0] = '{16'd1000, 16'd100, 16'd20, 16'd100, 16'd50, 16'd300};
    plan[1] = '{16'd40000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
    plan[2] = '{16'd65535, 16'd1, 16'd65535, 16'd65535, 16'd65535, 16'd65535};
    plan[3] = '{16'd30000, 16'd65535, 16'd7, 16'd13, 16'd3, 16'd29};
    plan[4] = '{16'd65535, 16'd0, 16'd10, 16'd20, 16'd10, 16'd40};
    plan_ticks = '{250, 120, 70, 40, 180};
    plan_run   = '{60, 20, 20, 10, 40};

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: baseline zero, no press is possible.
    send_tick(16'd0, 16'd0);
    send_tick(16'd5, 16'hffff);
    settle();

    // Press across the time wrap: threshold edges, bounce in lockout, held,
    // repeat, long hold lingering on release, quick re-press.
    apply_setting('{16'd1000, 16'd100, 16'd20, 16'd30, 16'd20, 16'd60});
    for (int k = 0; k < 20; k++) begin
      case (k)
        0, 3, 16, 17, 19: touch = 16'hffff;
        1:                touch = 16'd900;
        4:                touch = 16'd899;
        default:          touch = (k % 2 != 0) ? 16'd899 : 16'd0;
      endcase
      send_tick(16'(65480 + 10 * k), touch);
    end
    send_tick(16'hffff, 16'hffff);
    clock_ms = 16'hffff;

    for (int p = 0; p < 5; p++) begin
      settle();
      apply_setting(plan[p]);
      run_ticks(plan_ticks[p], plan_run[p]);
    end

    // One long press through held, repeats and long hold, then release.
    settle();
    apply_setting('{16'd65535, 16'd0, 16'd0, 16'd300, 16'd50, 16'd800});
    repeat (100) begin
      clock_ms = clock_ms + 16'(LOOP_MS);
      send_tick(clock_ms, pick_touch(1'b1));
    end
    repeat (10) begin
      clock_ms = clock_ms + 16'(LOOP_MS);
      send_tick(clock_ms, pick_touch(1'b0));
    end
    settle();
    repeat (10) @(negedge clk);

    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

### sim.f
rtl/core/tkdhr_pkg.sv
rtl/core/tkdhr_cfg.sv
rtl/core/tkdhr_front.sv
rtl/core/tkdhr_eval.sv
rtl/core/touch_key_debounce_hold_repeat_core.sv
tb/sv/tkdhr_checker.sv
tb/sv/tb_top.sv
